FILE: sv/mbc_pkg.sv
// Package for the memory test word checker: widths, action codes, register
// indexes, the queue entry and result types, and the xorshift32 step.
// Depends on nothing; every module of the checker uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mbc_pkg;

    localparam int WORD_W      = 32;
    localparam int INDEX_W     = 30;
    localparam int ACTION_W    = 2;
    localparam int LOG_SEL_W   = 4;
    localparam int LOG_DEPTH   = 16;
    localparam int LOG_IDX_W   = $clog2(LOG_DEPTH);
    localparam int FILL_W      = $clog2(LOG_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    // Slave tdata: read_data, log_index, padded to whole bytes.
    localparam int S_DATA_W = ((WORD_W + LOG_SEL_W + 7) / 8) * 8;
    // Master tdata: all eleven result fields, padded to whole bytes.
    localparam int M_FIELDS_W = 1 + 5 * WORD_W + FILL_W + 1 + 3 * WORD_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READLOG = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd3;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [WORD_W-1:0]    got;
        logic [WORD_W-1:0]    expected;
        logic [WORD_W-1:0]    address;
        logic [LOG_SEL_W-1:0] log_index;
    } t_mbc_entry;

    typedef struct packed {
        logic              word_failed;
        logic [WORD_W-1:0] expected_word;
        logic [WORD_W-1:0] error_count;
        logic [WORD_W-1:0] bad_bits;
        logic [WORD_W-1:0] bad_bits_even;
        logic [WORD_W-1:0] bad_bits_odd;
        logic [FILL_W-1:0] fail_count;
        logic              log_valid;
        logic [WORD_W-1:0] log_address;
        logic [WORD_W-1:0] log_expected;
        logic [WORD_W-1:0] log_got;
    } t_mbc_result;

    function automatic logic [WORD_W-1:0] next_random(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

`default_nettype wire

FILE: sv/mbc_front.sv
// Front part of the checker: holds the configuration registers, the pattern
// generator and the word index, and turns each item into a queue entry.
// Depends on mbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbc_front (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [mbc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [mbc_pkg::WORD_W-1:0]            i_cfg_data,
    input  wire                                   i_valid,
    input  wire  [mbc_pkg::ACTION_W-1:0]          i_action,
    input  wire  [mbc_pkg::WORD_W-1:0]            i_read_data,
    input  wire  [mbc_pkg::LOG_SEL_W-1:0]         i_log_index,
    input  wire                                   i_queue_full,
    output logic                                  o_ready,
    output logic                                  o_push,
    output mbc_pkg::t_mbc_entry                   o_entry
);

    logic                         r_mode;
    logic [mbc_pkg::WORD_W-1:0]   r_pattern;
    logic [mbc_pkg::WORD_W-1:0]   r_seed;
    logic [mbc_pkg::WORD_W-1:0]   r_base;
    logic [mbc_pkg::WORD_W-1:0]   r_gen;
    logic [mbc_pkg::INDEX_W-1:0]  r_index;

    logic [mbc_pkg::WORD_W-1:0]   n_gen;
    logic [mbc_pkg::INDEX_W-1:0]  n_index;
    logic [mbc_pkg::WORD_W-1:0]   w_step;
    logic                         w_check;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;
    assign w_step  = mbc_pkg::next_random(r_gen);
    assign w_check = (i_action == mbc_pkg::ACT_CHECK);

    always_comb begin
        o_entry.action    = i_action;
        o_entry.got       = i_read_data;
        o_entry.log_index = i_log_index;
        o_entry.address   = r_base + {r_index, 2'b00};
        if (!w_check) begin
            o_entry.expected = '0;
        end else if (r_mode) begin
            o_entry.expected = w_step;
        end else begin
            o_entry.expected = r_pattern;
        end
    end

    always_comb begin
        n_gen   = r_gen;
        n_index = r_index;
        if (o_push) begin
            unique case (i_action)
                mbc_pkg::ACT_RESTART: begin
                    n_gen   = (r_seed == '0) ? mbc_pkg::WORD_W'(1) : r_seed;
                    n_index = '0;
                end
                mbc_pkg::ACT_CHECK: begin
                    if (r_mode) begin
                        n_gen = w_step;
                    end
                    n_index = r_index + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_pattern <= '0;
            r_seed    <= '0;
            r_base    <= '0;
            r_gen     <= mbc_pkg::WORD_W'(1);
            r_index   <= '0;
        end else begin
            r_gen   <= n_gen;
            r_index <= n_index;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mbc_pkg::CFG_MODE:    r_mode    <= i_cfg_data[0];
                    mbc_pkg::CFG_PATTERN: r_pattern <= i_cfg_data;
                    mbc_pkg::CFG_SEED:    r_seed    <= i_cfg_data;
                    mbc_pkg::CFG_BASE:    r_base    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/mbc_queue.sv
// Short queue of classified items between the front and the back parts.
// Depends on mbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbc_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  mbc_pkg::t_mbc_entry  i_entry,
    input  wire                  i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output mbc_pkg::t_mbc_entry  o_entry
);

    mbc_pkg::t_mbc_entry               r_slot [mbc_pkg::QUEUE_DEPTH];
    logic [mbc_pkg::QPTR_W-1:0]        r_wptr;
    logic [mbc_pkg::QPTR_W-1:0]        r_rptr;
    logic [mbc_pkg::QCNT_W-1:0]        r_count;

    assign o_full  = (r_count == mbc_pkg::QCNT_W'(mbc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rptr];

    function automatic logic [mbc_pkg::QPTR_W-1:0] bump(input logic [mbc_pkg::QPTR_W-1:0] p);
        return (p == mbc_pkg::QPTR_W'(mbc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/mbc_back.sv
// Back part of the checker: error count, bad-bit masks, fail log, and the
// output register that holds one result until it is taken.
// Depends on mbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  mbc_pkg::t_mbc_entry  i_entry,
    output logic                 o_pop,
    input  wire                  i_ready,
    output logic                 o_valid,
    output mbc_pkg::t_mbc_result o_result
);

    logic [mbc_pkg::WORD_W-1:0]  r_errors;
    logic [mbc_pkg::WORD_W-1:0]  r_mask_all;
    logic [mbc_pkg::WORD_W-1:0]  r_mask_even;
    logic [mbc_pkg::WORD_W-1:0]  r_mask_odd;
    logic [mbc_pkg::FILL_W-1:0]  r_fill;
    logic                        r_out_valid;
    mbc_pkg::t_mbc_result        r_result;

    logic [mbc_pkg::WORD_W-1:0]  r_log_addr [mbc_pkg::LOG_DEPTH];
    logic [mbc_pkg::WORD_W-1:0]  r_log_exp  [mbc_pkg::LOG_DEPTH];
    logic [mbc_pkg::WORD_W-1:0]  r_log_got  [mbc_pkg::LOG_DEPTH];

    logic [mbc_pkg::WORD_W-1:0]  n_errors;
    logic [mbc_pkg::WORD_W-1:0]  n_mask_all;
    logic [mbc_pkg::WORD_W-1:0]  n_mask_even;
    logic [mbc_pkg::WORD_W-1:0]  n_mask_odd;
    logic [mbc_pkg::FILL_W-1:0]  n_fill;
    mbc_pkg::t_mbc_result        n_result;

    logic [mbc_pkg::WORD_W-1:0]  w_diff;
    logic                        w_fail;
    logic                        w_log_write;
    logic                        w_log_hit;

    assign o_pop    = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    assign w_diff      = i_entry.expected ^ i_entry.got;
    assign w_fail      = (i_entry.action == mbc_pkg::ACT_CHECK) && (w_diff != '0);
    assign w_log_write = o_pop && w_fail
                         && (r_fill < mbc_pkg::FILL_W'(mbc_pkg::LOG_DEPTH));
    assign w_log_hit   = (i_entry.action == mbc_pkg::ACT_READLOG)
                         && ({1'b0, i_entry.log_index} < r_fill);

    always_comb begin
        n_errors    = r_errors;
        n_mask_all  = r_mask_all;
        n_mask_even = r_mask_even;
        n_mask_odd  = r_mask_odd;
        n_fill      = r_fill;
        if (i_entry.action == mbc_pkg::ACT_CLEAR) begin
            n_errors    = '0;
            n_mask_all  = '0;
            n_mask_even = '0;
            n_mask_odd  = '0;
            n_fill      = '0;
        end else if (w_fail) begin
            if (r_errors != '1) begin
                n_errors = r_errors + 1'b1;
            end
            n_mask_all = r_mask_all | w_diff;
            // Bit 2 of the byte address tells odd words from even ones.
            if (i_entry.address[2]) begin
                n_mask_odd = r_mask_odd | w_diff;
            end else begin
                n_mask_even = r_mask_even | w_diff;
            end
            if (r_fill < mbc_pkg::FILL_W'(mbc_pkg::LOG_DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
        end

        n_result.word_failed   = w_fail;
        n_result.expected_word = i_entry.expected;
        n_result.error_count   = n_errors;
        n_result.bad_bits      = n_mask_all;
        n_result.bad_bits_even = n_mask_even;
        n_result.bad_bits_odd  = n_mask_odd;
        n_result.fail_count    = n_fill;
        n_result.log_valid     = w_log_hit;
        n_result.log_address   = w_log_hit ? r_log_addr[i_entry.log_index] : '0;
        n_result.log_expected  = w_log_hit ? r_log_exp[i_entry.log_index] : '0;
        n_result.log_got       = w_log_hit ? r_log_got[i_entry.log_index] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_log_write) begin
            r_log_addr[r_fill[mbc_pkg::LOG_IDX_W-1:0]] <= i_entry.address;
            r_log_exp[r_fill[mbc_pkg::LOG_IDX_W-1:0]]  <= i_entry.expected;
            r_log_got[r_fill[mbc_pkg::LOG_IDX_W-1:0]]  <= i_entry.got;
        end
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_errors    <= '0;
            r_mask_all  <= '0;
            r_mask_even <= '0;
            r_mask_odd  <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_errors    <= n_errors;
                r_mask_all  <= n_mask_all;
                r_mask_even <= n_mask_even;
                r_mask_odd  <= n_mask_odd;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/memory_test_word_checker.sv
// Top level of the memory test word checker: ports, stream packing, and the
// front, queue and back parts. Depends on mbc_pkg, mbc_front, mbc_queue, mbc_back.
`timescale 1ns / 1ps
`default_nettype none

// The checker takes one item per clock unless stalled and returns exactly one
// result item for each, in order. The tuser action selects what an item does:
// clear the error count, masks and fail log; restart a pass, which reloads the
// pattern generator from the seed (a zero seed counts as one) and sets the word
// index to zero; check one read-back word; or read one fail log entry. A check
// compares the word with the fill pattern in fixed mode or with the next
// xorshift32 value in random mode, counts a mismatch in a saturating error
// count, ORs the differing bits into an overall mask and into an even or odd
// mask chosen by bit 2 of the word's byte address, and logs the first sixteen
// mismatches. Every result carries the counts and masks as they stand after
// that item. The front part forms the expected word and address from the
// generator and word index in the cycle in which the item is accepted, and
// writes them into the queue at that edge. The back part takes the entry from
// the queue once its output register is empty or being taken, updates the
// error state and fail log, and registers the result. With the output taken at
// every cycle the sustained rate is one item per cycle. A two-entry queue
// between the parts and the output register let the input side accept up to
// two more items while a result waits; after that the input stalls until the
// result is taken. Configuration is written through a plain write port and
// should only be changed while no items are in flight.
module memory_test_word_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    // Configuration: index 0 mode, 1 fill pattern, 2 seed, 3 base address.
    input  wire                              i_cfg_we,
    input  wire  [mbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [mbc_pkg::WORD_W-1:0]       i_cfg_data,

    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // Fields from bit 0 up: read_data[31:0], log_index[35:32], zero padding.
    input  wire  [mbc_pkg::S_DATA_W-1:0]     i_s_tdata,
    // Fields from bit 0 up: action[1:0].
    input  wire  [mbc_pkg::ACTION_W-1:0]     i_s_tuser,

    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // Fields from bit 0 up: word_failed, expected_word, error_count, bad_bits,
    // bad_bits_even, bad_bits_odd, fail_count (5 bits), log_valid,
    // log_address, log_expected, log_got, then zero padding.
    output logic [mbc_pkg::M_DATA_W-1:0]     o_m_tdata
);

    logic                  w_push;
    logic                  w_pop;
    logic                  w_queue_full;
    logic                  w_queue_valid;
    mbc_pkg::t_mbc_entry   w_front_entry;
    mbc_pkg::t_mbc_entry   w_back_entry;
    mbc_pkg::t_mbc_result  w_result;

    mbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_tvalid),
        .i_action     (i_s_tuser),
        .i_read_data  (i_s_tdata[mbc_pkg::WORD_W-1:0]),
        .i_log_index  (i_s_tdata[mbc_pkg::WORD_W +: mbc_pkg::LOG_SEL_W]),
        .i_queue_full (w_queue_full),
        .o_ready      (o_s_tready),
        .o_push       (w_push),
        .o_entry      (w_front_entry)
    );

    mbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_full  (w_queue_full),
        .o_valid (w_queue_valid),
        .o_entry (w_back_entry)
    );

    mbc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_queue_valid),
        .i_entry  (w_back_entry),
        .o_pop    (w_pop),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_result (w_result)
    );

    // The result struct lists its fields from the most significant end, so
    // they are laid out here explicitly with word_failed at bit 0.
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[0]       = w_result.word_failed;
        o_m_tdata[32:1]    = w_result.expected_word;
        o_m_tdata[64:33]   = w_result.error_count;
        o_m_tdata[96:65]   = w_result.bad_bits;
        o_m_tdata[128:97]  = w_result.bad_bits_even;
        o_m_tdata[160:129] = w_result.bad_bits_odd;
        o_m_tdata[165:161] = w_result.fail_count;
        o_m_tdata[166]     = w_result.log_valid;
        o_m_tdata[198:167] = w_result.log_address;
        o_m_tdata[230:199] = w_result.log_expected;
        o_m_tdata[262:231] = w_result.log_got;
    end

endmodule

`default_nettype wire
